FILE: rtl/crt_pkg.sv
// ============================================================================
// crt_pkg
// Shared types, field widths, status codes and controller step codes for the
// congruence combiner.
// ============================================================================
`default_nettype none

package crt_pkg;

  // Field widths of the item interfaces
  localparam int RES_W        = 64;
  localparam int MOD_W        = 62;
  localparam int STAT_W       = 2;
  localparam int DEF_MOD_BITS = 62;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSOL = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd2;

  // Datapath step codes issued by the controller
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_LOAD = 4'd0;
  localparam logic [STEP_W-1:0] STEP_BRED = 4'd1;
  localparam logic [STEP_W-1:0] STEP_GCD  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_AG   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_BG   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_M1G  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_LCM  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_M2G  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_AM2  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_XQ   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_R0   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_INV  = 4'd11;
  localparam logic [STEP_W-1:0] STEP_KMM  = 4'd12;
  localparam logic [STEP_W-1:0] STEP_RES  = 4'd13;
  localparam logic [STEP_W-1:0] STEP_FIN  = 4'd14;

  typedef struct packed {
    logic                    start_req;
    logic signed [RES_W-1:0] residue;
    logic [MOD_W-1:0]        modulus;
  } in_item_t;

  typedef struct packed {
    logic [MOD_W-1:0]  combined_residue;
    logic [MOD_W-1:0]  combined_modulus;
    logic [STAT_W-1:0] status;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic              go;    // launch the iterative unit for this step
    logic              wb;    // write back the result of this step
    logic [STEP_W-1:0] step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;
    logic fail_nz;
    logic q_zero;
    logic r1_zero;
    logic m2g_le1;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/crt_dp.sv
// ============================================================================
// crt_dp
// Datapath: operand registers, accumulator state and one shared iterative
// unit (restoring divider with quotient-driven multiply-accumulate,
// shift-and-add multiplier with overflow, shift-and-add modular multiplier).
// ============================================================================
`default_nettype none

module crt_dp #(
  parameter int MOD_BITS = crt_pkg::DEF_MOD_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire crt_pkg::cmd_t      cmd,
  input  wire crt_pkg::in_item_t  in_data,
  output crt_pkg::stat_t          stat,
  output crt_pkg::out_item_t      out_data
);

  localparam int W      = MOD_BITS;
  localparam int RW     = crt_pkg::RES_W;
  localparam int SW     = MOD_BITS + 3;
  localparam int MAXS   = (2 * MOD_BITS > RW) ? 2 * MOD_BITS : RW;
  localparam int CNT_W  = $clog2(MAXS);
  localparam logic [1:0] OP_DIV = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_MM  = 2'd2;

  // Accumulated system and per-item operands
  logic [crt_pkg::STAT_W-1:0] fail_r;
  logic [W-1:0] accr_r, accm_r;
  logic [W-1:0] m1_r, m2_r, a_r, b_r, p_r, q_r, ag_r;
  logic [W-1:0] m1g_r, m2g_r, lcm_r, x_r, r0_r, r1_r, k_r, res_r;
  logic signed [SW-1:0] s0_r, s1_r;
  logic [RW-1:0] mag_r;
  logic          neg_r;
  crt_pkg::out_item_t out_r;

  // Iterative unit
  logic             busy_r, ovf_r;
  logic [1:0]       op_r;
  logic [CNT_W-1:0] cnt_r;
  logic [RW-1:0]    sh_r;
  logic [W-1:0]     d_r, mc_r, rem_r, quo_r;
  logic [W+1:0]     pacc_r;
  logic signed [SW-1:0] macc_r;

  // Load-time values
  logic            ld_start;
  logic [W-1:0]    ld_accm, ld_accr, ld_mod;
  logic [RW-1:0]   ld_mag;

  // Unit launch operands
  logic [1:0]       go_op;
  logic [CNT_W-1:0] go_cnt;
  logic [RW-1:0]    go_sh;
  logic [W-1:0]     go_d, go_mc;

  // Unit step values
  logic [W:0]       div_t, div_v, dbl_t, dbl_v, add_t, add_v;
  logic             div_ge;
  logic [W+1:0]     mul_t;
  logic signed [SW-1:0] macc_step, inv_s;
  logic [W-1:0]     inv_v;
  logic [W:0]       diff_t, diff_v;

  // Apply a start request to the stored system
  always_comb begin
    ld_start = in_data.start_req;
    ld_accm  = ld_start ? W'(1) : accm_r;
    ld_accr  = ld_start ? '0 : accr_r;
    ld_mod   = in_data.modulus[W-1:0];
    ld_mag   = in_data.residue[RW-1] ? (~in_data.residue + RW'(1)) : in_data.residue;
  end

  function automatic logic [RW-1:0] zx(input logic [W-1:0] v);
    zx = RW'(v);
  endfunction

  function automatic logic [RW-1:0] top(input logic [W-1:0] v);
    top = {v, {(RW-W){1'b0}}};
  endfunction

  // Select unit operands for the launched step
  always_comb begin
    go_op  = OP_DIV;
    go_cnt = CNT_W'(RW - 1);
    go_sh  = zx(m1_r);
    go_d   = p_r;
    go_mc  = m2_r;
    case (cmd.step)
      crt_pkg::STEP_BRED: begin go_sh = mag_r;   go_d = m2_r; end
      crt_pkg::STEP_GCD:  begin go_sh = zx(p_r); go_d = q_r;  end
      crt_pkg::STEP_AG:   begin go_sh = zx(a_r); go_d = p_r;  end
      crt_pkg::STEP_BG:   begin go_sh = zx(b_r); go_d = p_r;  end
      crt_pkg::STEP_M1G:  begin go_sh = zx(m1_r); go_d = p_r; end
      crt_pkg::STEP_M2G:  begin go_sh = zx(m2_r); go_d = p_r; end
      crt_pkg::STEP_AM2:  begin go_sh = zx(a_r); go_d = m2_r; end
      crt_pkg::STEP_XQ:   begin go_sh = zx(x_r); go_d = p_r;  end
      crt_pkg::STEP_R0:   begin go_sh = zx(m1g_r); go_d = m2g_r; end
      crt_pkg::STEP_INV:  begin go_sh = zx(r0_r); go_d = r1_r; end
      crt_pkg::STEP_LCM: begin
        go_op = OP_MUL; go_cnt = CNT_W'(W - 1); go_sh = top(m1g_r); go_mc = m2_r;
      end
      crt_pkg::STEP_RES: begin
        go_op = OP_MUL; go_cnt = CNT_W'(W - 1); go_sh = top(k_r); go_mc = m1_r;
      end
      crt_pkg::STEP_KMM: begin
        go_op = OP_MM; go_cnt = CNT_W'(2 * W - 1); go_sh = top(inv_v);
        go_mc = x_r; go_d = m2g_r;
      end
      default: ;
    endcase
  end

  // One step of each unit operation
  always_comb begin
    div_t     = {rem_r, sh_r[RW-1]};
    div_ge    = div_t >= {1'b0, d_r};
    div_v     = div_ge ? (div_t - {1'b0, d_r}) : div_t;
    macc_step = (macc_r <<< 1) + (div_ge ? s1_r : '0);
    mul_t     = {pacc_r[W:0], 1'b0} + (sh_r[RW-1] ? {2'b00, mc_r} : '0);
    dbl_t     = {pacc_r[W-1:0], 1'b0};
    dbl_v     = (dbl_t >= {1'b0, d_r}) ? (dbl_t - {1'b0, d_r}) : dbl_t;
    add_t     = {1'b0, pacc_r[W-1:0]} + {1'b0, mc_r};
    add_v     = (add_t >= {1'b0, d_r}) ? (add_t - {1'b0, d_r}) : add_t;
    inv_s     = s0_r[SW-1] ? (s0_r + SW'(m2g_r)) : s0_r;
    inv_v     = inv_s[W-1:0];
    diff_t    = {1'b0, b_r} + {1'b0, m2_r} - {1'b0, rem_r};
    diff_v    = (diff_t >= {1'b0, m2_r}) ? (diff_t - {1'b0, m2_r}) : diff_t;
  end

  // Run the iterative unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.go) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      op_r   <= go_op;
      cnt_r  <= go_cnt;
      sh_r   <= go_sh;
      d_r    <= go_d;
      mc_r   <= go_mc;
      rem_r  <= '0;
      quo_r  <= '0;
      pacc_r <= '0;
      macc_r <= '0;
      ovf_r  <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      case (op_r)
        OP_DIV: begin
          rem_r  <= div_v[W-1:0];
          quo_r  <= {quo_r[W-2:0], div_ge};
          macc_r <= macc_step;
          sh_r   <= sh_r << 1;
        end
        OP_MUL: begin
          sh_r <= sh_r << 1;
          if (!ovf_r) begin
            pacc_r <= mul_t;
            if (mul_t[W+1:W] != 2'b00) ovf_r <= 1'b1;
          end
        end
        OP_MM: begin
          // odd counts double, even counts add the multiplicand if the multiplier bit is set
          if (cnt_r[0]) begin
            pacc_r <= {1'b0, dbl_v};
          end else begin
            pacc_r <= sh_r[RW-1] ? {1'b0, add_v} : pacc_r;
            sh_r   <= sh_r << 1;
          end
        end
        default: ;
      endcase
    end
  end

  // Accumulated system and failure code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_r <= crt_pkg::ST_OK;
      accr_r <= '0;
      accm_r <= W'(1);
    end else if (cmd.wb) begin
      case (cmd.step)
        crt_pkg::STEP_LOAD: if (ld_start) fail_r <= crt_pkg::ST_OK;
        crt_pkg::STEP_BG:   if (rem_r != ag_r) fail_r <= crt_pkg::ST_NOSOL;
        crt_pkg::STEP_LCM:  if (ovf_r) fail_r <= crt_pkg::ST_OVF;
        crt_pkg::STEP_FIN: begin
          accr_r <= (fail_r != crt_pkg::ST_OK) ? '0 : res_r;
          accm_r <= (fail_r != crt_pkg::ST_OK) ? '0 : lcm_r;
        end
        default: ;
      endcase
    end
  end

  // Write back step results
  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      case (cmd.step)
        crt_pkg::STEP_LOAD: begin
          m1_r  <= (ld_accm == '0) ? W'(1) : ld_accm;
          a_r   <= (ld_accm == '0) ? '0 : ld_accr;
          m2_r  <= (ld_mod == '0) ? W'(1) : ld_mod;
          mag_r <= ld_mag;
          neg_r <= in_data.residue[RW-1];
        end
        crt_pkg::STEP_BRED: begin
          b_r <= (neg_r && rem_r != '0) ? (m2_r - rem_r) : rem_r;
          p_r <= m1_r;
          q_r <= m2_r;
        end
        crt_pkg::STEP_GCD: begin
          p_r <= q_r;
          q_r <= rem_r;
        end
        crt_pkg::STEP_AG:  ag_r  <= rem_r;
        crt_pkg::STEP_M1G: m1g_r <= quo_r;
        crt_pkg::STEP_LCM: lcm_r <= pacc_r[W-1:0];
        crt_pkg::STEP_M2G: begin
          m2g_r <= quo_r;
          k_r   <= '0;
        end
        crt_pkg::STEP_AM2: x_r <= diff_v[W-1:0];
        crt_pkg::STEP_XQ:  x_r <= quo_r;
        crt_pkg::STEP_R0: begin
          r0_r <= rem_r;
          r1_r <= m2g_r;
          s0_r <= SW'(1);
          s1_r <= '0;
        end
        crt_pkg::STEP_INV: begin
          r0_r <= r1_r;
          r1_r <= rem_r;
          s0_r <= s1_r;
          s1_r <= s0_r - macc_r;
        end
        crt_pkg::STEP_KMM: k_r   <= pacc_r[W-1:0];
        crt_pkg::STEP_RES: res_r <= pacc_r[W-1:0] + a_r;
        crt_pkg::STEP_FIN: begin
          if (fail_r != crt_pkg::ST_OK) begin
            out_r.combined_residue <= '0;
            out_r.combined_modulus <= '0;
            out_r.status           <= fail_r;
          end else begin
            out_r.combined_residue <= crt_pkg::MOD_W'(res_r);
            out_r.combined_modulus <= crt_pkg::MOD_W'(lcm_r);
            out_r.status           <= crt_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  // Status toward the controller
  always_comb begin
    stat.busy    = busy_r;
    stat.fail_nz = fail_r != crt_pkg::ST_OK;
    stat.q_zero  = q_r == '0;
    stat.r1_zero = r1_r == '0;
    stat.m2g_le1 = m2g_r <= W'(1);
    out_data     = out_r;
  end

endmodule

`default_nettype wire

FILE: rtl/crt_ctrl.sv
// ============================================================================
// crt_ctrl
// Controller: sequences the datapath steps of one item, runs the gcd and
// inverse loops, and owns both channel handshakes.
// ============================================================================
`default_nettype none

module crt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire crt_pkg::stat_t stat,
  output crt_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_BRED = crt_pkg::STEP_BRED;
  localparam logic [3:0] S_GCD  = crt_pkg::STEP_GCD;
  localparam logic [3:0] S_AG   = crt_pkg::STEP_AG;
  localparam logic [3:0] S_BG   = crt_pkg::STEP_BG;
  localparam logic [3:0] S_M1G  = crt_pkg::STEP_M1G;
  localparam logic [3:0] S_LCM  = crt_pkg::STEP_LCM;
  localparam logic [3:0] S_M2G  = crt_pkg::STEP_M2G;
  localparam logic [3:0] S_AM2  = crt_pkg::STEP_AM2;
  localparam logic [3:0] S_XQ   = crt_pkg::STEP_XQ;
  localparam logic [3:0] S_R0   = crt_pkg::STEP_R0;
  localparam logic [3:0] S_INV  = crt_pkg::STEP_INV;
  localparam logic [3:0] S_KMM  = crt_pkg::STEP_KMM;
  localparam logic [3:0] S_RES  = crt_pkg::STEP_RES;
  localparam logic [3:0] S_FIN  = crt_pkg::STEP_FIN;
  localparam logic [3:0] S_IDLE = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic       run_r, run_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       skip, emit;
  logic [3:0] skip_to, next_to;

  // Per-state skip test and successor
  always_comb begin
    skip    = 1'b0;
    skip_to = S_FIN;
    next_to = S_FIN;
    unique case (state_r)
      S_BRED: begin skip = stat.fail_nz; next_to = S_GCD; end
      S_GCD:  begin skip = stat.q_zero; skip_to = S_AG; next_to = S_GCD; end
      S_AG:   next_to = S_BG;
      S_BG:   next_to = S_M1G;
      S_M1G:  begin skip = stat.fail_nz; next_to = S_LCM; end
      S_LCM:  next_to = S_M2G;
      S_M2G:  begin skip = stat.fail_nz; next_to = S_AM2; end
      S_AM2:  begin skip = stat.m2g_le1; skip_to = S_RES; next_to = S_XQ; end
      S_XQ:   next_to = S_R0;
      S_R0:   next_to = S_INV;
      S_INV:  begin skip = stat.r1_zero; skip_to = S_KMM; next_to = S_INV; end
      S_KMM:  next_to = S_RES;
      S_RES:  next_to = S_FIN;
      default: ;
    endcase
  end

  // Sequence the steps
  always_comb begin
    state_nxt = state_r;
    run_nxt   = run_r;
    emit      = 1'b0;
    cmd.go    = 1'b0;
    cmd.wb    = 1'b0;
    cmd.step  = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.step = crt_pkg::STEP_LOAD;
        if (in_valid) begin
          cmd.wb    = 1'b1;
          state_nxt = S_BRED;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.wb    = 1'b1;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_BRED, S_GCD, S_AG, S_BG, S_M1G, S_LCM, S_M2G, S_AM2, S_XQ, S_R0, S_INV,
      S_KMM, S_RES: begin
        if (!run_r) begin
          if (skip) begin
            state_nxt = skip_to;
          end else begin
            cmd.go  = 1'b1;
            run_nxt = 1'b1;
          end
        end else if (!stat.busy) begin
          cmd.wb    = 1'b1;
          run_nxt   = 1'b0;
          state_nxt = next_to;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold a result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/crt_congruence_combiner.sv
// ============================================================================
// crt_congruence_combiner
// Folds a stream of congruences x = r (mod m) into one combined congruence,
// moduli not necessarily coprime, with sticky failure and overflow flagging.
// ============================================================================
// One item is worked on at a time; every arithmetic step runs on a single
// shared iterative unit in the datapath. A division runs 64 one-bit
// restoring steps between launch and write-back; the lcm and final residue
// use the shift-and-add multiplier, and the modular multiply its own mode.
// A consistent item whose modulus does not divide the combined one runs the
// gcd loop for gcd(M, m) and the inverse loop; when the new modulus divides
// the combined one, the inverse and modular multiply are dropped. An
// inconsistent item ends after the consistency check, an lcm overflow after
// the lcm, and an item that meets a stored failure without start_req goes
// straight to the result. The block takes no new item until the current
// one's result is loaded into the output register; that register holds the
// result while out_stall is high.
`default_nettype none

module crt_congruence_combiner #(
  parameter int MOD_BITS = crt_pkg::DEF_MOD_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire crt_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output crt_pkg::out_item_t      out_data
);

  crt_pkg::cmd_t  cmd;
  crt_pkg::stat_t stat;

  // Step sequencer and handshakes
  crt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Operands, state and iterative unit
  crt_dp #(
    .MOD_BITS (MOD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Congruence combiner testbench
// Drives directed and random congruence streams, with random idle gaps on
// the input side and random stalls on the result side. A class folds each
// accepted congruence into its own combined congruence and compares every
// result from the block against it, field by field, in order.
// ----------------------------------------------------------------------------

class crt_fold_board;
  localparam bit [63:0] MOD_MAX = (64'd1 << crt_pkg::DEF_MOD_BITS) - 64'd1;

  bit [63:0]            sys_residue;
  bit [63:0]            sys_modulus;
  bit [1:0]             sys_fail;
  crt_pkg::out_item_t   pending_folds[$];
  int                   errors;

  function new();
    sys_residue = 0;
    sys_modulus = 1;
    sys_fail    = crt_pkg::ST_OK;
    errors      = 0;
  endfunction

  function bit [63:0] gcd64(bit [63:0] p, bit [63:0] q);
    bit [63:0] t;
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    return p;
  endfunction

  // inverse of p modulo q, q > 1, p and q coprime
  function bit [63:0] inverse_mod(bit [63:0] p, bit [63:0] q);
    longint r0, r1, s0, s1, qt, t;
    r0 = longint'(p % q);
    r1 = longint'(q);
    s0 = 1;
    s1 = 0;
    while (r1 != 0) begin
      qt = r0 / r1;
      t  = r0 - qt * r1;
      r0 = r1;
      r1 = t;
      t  = s0 - qt * s1;
      s0 = s1;
      s1 = t;
    end
    s0 = s0 % longint'(q);
    if (s0 < 0) s0 += longint'(q);
    return 64'(s0);
  endfunction

  // signed residue reduced into [0, m)
  function bit [63:0] reduce_residue(bit [63:0] raw, bit [63:0] m);
    bit [63:0] r;
    if (raw[63]) begin
      r = (~raw + 64'd1) % m;
      return (r != 0) ? m - r : 64'd0;
    end
    return raw % m;
  endfunction

  // fold one accepted congruence into the system and queue its result
  function void note_congruence(crt_pkg::in_item_t it);
    bit [63:0]          m1, m2, a, b, g, m1g, m2g, k, diff;
    bit [127:0]         prod;
    crt_pkg::out_item_t res;
    if (it.start_req) begin
      sys_residue = 0;
      sys_modulus = 1;
      sys_fail    = crt_pkg::ST_OK;
    end
    if (sys_fail == crt_pkg::ST_OK) begin
      m1 = sys_modulus & MOD_MAX;
      if (m1 == 0) m1 = 1;
      m2 = 64'(it.modulus) & MOD_MAX;
      if (m2 == 0) m2 = 1;
      a = (sys_residue & MOD_MAX) % m1;
      b = reduce_residue(it.residue, m2);
      g = gcd64(m1, m2);
      if (a % g != b % g) begin
        sys_fail = crt_pkg::ST_NOSOL;
      end else begin
        m1g = m1 / g;
        if (m1g > MOD_MAX / m2) begin
          sys_fail = crt_pkg::ST_OVF;
        end else begin
          m2g = m2 / g;
          k = 0;
          if (m2g > 1) begin
            diff = (b + m2 - (a % m2)) % m2;
            prod = 128'((diff / g) % m2g) * 128'(inverse_mod(m1g, m2g));
            k = 64'(prod % 128'(m2g));
          end
          sys_residue = a + m1 * k;
          sys_modulus = m1g * m2;
        end
      end
      if (sys_fail != crt_pkg::ST_OK) begin
        sys_residue = 0;
        sys_modulus = 0;
      end
    end
    if (sys_fail != crt_pkg::ST_OK) begin
      res.combined_residue = '0;
      res.combined_modulus = '0;
      res.status           = sys_fail;
    end else begin
      res.combined_residue = sys_residue[crt_pkg::MOD_W-1:0];
      res.combined_modulus = sys_modulus[crt_pkg::MOD_W-1:0];
      res.status           = crt_pkg::ST_OK;
    end
    pending_folds.push_back(res);
  endfunction

  // compare one result with the oldest pending fold
  function void check_combined(crt_pkg::out_item_t got);
    crt_pkg::out_item_t want;
    if (pending_folds.size() == 0) begin
      $display("%0t: unexpected result actual %h", $time, got);
      errors++;
      return;
    end
    want = pending_folds.pop_front();
    if (got.combined_residue !== want.combined_residue) begin
      $display("%0t: residue expected %0d actual %0d", $time,
               want.combined_residue, got.combined_residue);
      errors++;
    end
    if (got.combined_modulus !== want.combined_modulus) begin
      $display("%0t: modulus expected %0d actual %0d", $time,
               want.combined_modulus, got.combined_modulus);
      errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time,
               want.status, got.status);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  crt_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  crt_pkg::out_item_t out_data;

  crt_fold_board board;
  int            stall_left;
  bit            no_idle;
  int            sent;

  crt_congruence_combiner u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // end the run if the block hangs
  initial begin
    #600_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // random stall after each accepted result; check accepted results
  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      board.check_combined(out_data);
      n = no_idle ? 0 : $urandom_range(0, 9);
      stall_left <= n;
      out_stall  <= (n != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  function automatic bit [63:0] rand_bits(int w);
    bit [63:0] v;
    v = {$urandom, $urandom};
    return (w >= 64) ? v : (v & ((64'd1 << w) - 64'd1));
  endfunction

  // hold one item until the block takes it
  task automatic send_congruence(bit st, bit [63:0] r, bit [61:0] m);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.start_req <= st;
    in_data.residue   <= r;
    in_data.modulus   <= m;
    do @(posedge clk); while (in_stall);
    board.note_congruence(in_data);
    sent++;
    if (sent % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
  endtask

  function automatic bit [61:0] pick_modulus();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 62'($urandom_range(1, 1000));
    if (sel < 85) return 62'(rand_bits(20));
    if (sel < 95) return 62'(rand_bits(40));
    return 62'(rand_bits(62));
  endfunction

  // one system built around a hidden solution, with some broken items
  task automatic run_system();
    bit [63:0] x, r;
    bit [61:0] m;
    longint    rr;
    int        n;
    x = rand_bits(64);
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      m = pick_modulus();
      if ($urandom_range(0, 99) < 87 && m != 0) begin
        r  = x % 64'(m);
        rr = longint'(r) + longint'(int'($urandom_range(0, 3)) - 2) * longint'(m);
        send_congruence(i == 0, 64'(rr), m);
      end else begin
        send_congruence(i == 0 || $urandom_range(0, 9) == 0, rand_bits(64), m);
      end
    end
  endtask

  initial begin
    bit [63:0] big_p;
    board     = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    no_idle   = 1'b0;
    sent      = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, zero modulus, failures, stickiness, restart
    send_congruence(1'b0, 64'h8000_0000_0000_0000, 62'd7);
    send_congruence(1'b0, 64'h7fff_ffff_ffff_ffff, 62'd9);
    send_congruence(1'b0, 64'hffff_ffff_ffff_ffff, 62'd0);
    send_congruence(1'b0, 64'd5, 62'd6);
    send_congruence(1'b0, 64'd0, 62'd4);
    send_congruence(1'b1, 64'd3, 62'd1);
    send_congruence(1'b0, 64'hffff_ffff_ffff_fffe, 62'h3fff_ffff_ffff_ffff);
    send_congruence(1'b0, 64'd1, 62'd3);
    send_congruence(1'b0, 64'd0, 62'd0);
    send_congruence(1'b1, 64'd2, 62'd4);
    send_congruence(1'b0, 64'd3, 62'd6);
    send_congruence(1'b0, 64'd2, 62'd10);
    send_congruence(1'b1, 64'h7fff_ffff_ffff_ffff, 62'h3fff_ffff_ffff_ffff);
    send_congruence(1'b0, 64'd1, 62'h3fff_ffff_ffff_fffe);
    send_congruence(1'b0, 64'd0, 62'd5);
    big_p = 64'd4294967291;
    send_congruence(1'b1, 64'd17, 62'(big_p));
    send_congruence(1'b0, 64'd23, 62'(big_p - 64'd2));
    send_congruence(1'b0, 64'd11, 62'(64'd2147483647));
    send_congruence(1'b1, 64'h8000_0000_0000_0000, 62'h2aaa_aaaa_aaaa_aaaa);
    send_congruence(1'b0, 64'h1234_5678_9abc_def0, 62'h1555_5555_5555_5555);

    // random systems with noise items mixed in
    while (sent < 900) begin
      if ($urandom_range(0, 9) == 0)
        send_congruence(1'($urandom_range(0, 1)), rand_bits(64), 62'(rand_bits(62)));
      else
        run_system();
    end
    @(posedge clk);
    in_valid <= 1'b0;

    // drain, then let the block settle
    while (board.pending_folds.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: crt_congruence_combiner.f
rtl/crt_pkg.sv
rtl/crt_dp.sv
rtl/crt_ctrl.sv
rtl/crt_congruence_combiner.sv
verif/testbench.sv
